[rtl/pool2d_max_avg_window_top_defines.svh]
// assertion macros shared by the checker
`ifndef POOL2D_MAX_AVG_WINDOW_TOP_DEFINES_SVH
`define POOL2D_MAX_AVG_WINDOW_TOP_DEFINES_SVH

// condition in one cycle implies a condition in the next
`define POOL2D_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("pool2d check failed");

// condition implies a condition in the same cycle
`define POOL2D_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("pool2d check failed");

`endif

[rtl/pool2d_pkg.sv]
// ----------------------------------------------------------------------------
// pool2d_pkg
// types, codes and window geometry shared by the pooling block
// ----------------------------------------------------------------------------
package pool2d_pkg;

  localparam int AXW = 16;
  typedef logic signed [AXW-1:0] axis_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ROW, S_COL, S_SCAN, S_DRAIN, S_DSTART, S_DIV, S_EMIT, S_FIN, S_CADV, S_RADV
  } state_e;

  typedef enum logic [2:0] {
    REG_MODE, REG_KERNEL, REG_STEP, REG_PAD, REG_HEIGHT, REG_WIDTH
  } reg_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  typedef struct packed {
    axis_t first;
    axis_t last;
    logic  ok;
    logic  hit;
  } win_t;

  // one window on one axis: clipped start and end, exists, ends at pos
  function automatic win_t win_calc(axis_t o, axis_t s, axis_t p, axis_t k,
                                    axis_t len, axis_t pos);
    win_t  w;
    axis_t start;
    axis_t endu;
    start   = o * s - p;
    endu    = start + k - axis_t'(1);
    w.last  = (endu > len - axis_t'(1)) ? len - axis_t'(1) : endu;
    w.first = (start < 0) ? axis_t'(0) : start;
    w.ok    = (start + k) <= (len + p);
    w.hit   = w.ok && (w.last == pos);
    return w;
  endfunction

endpackage

[rtl/pool2d_div.sv]
// ----------------------------------------------------------------------------
// pool2d_div
// signed by unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pool2d_div #(
  parameter int SUMW = 22,
  parameter int CNTW = 6
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [SUMW-1:0]     dividend_i,
  input  logic        [CNTW-1:0]     divisor_i,
  output logic signed [SUMW-1:0]     quot_o,
  output pool2d_pkg::div_sts_t       sts_o
);

  localparam int IW = $clog2(SUMW + 1);

  logic            busy_q, done_q, neg_q;
  logic [SUMW-1:0] q_q;
  logic [CNTW-1:0] rem_q, div_q;
  logic [IW-1:0]   it_q;
  logic [CNTW:0]   trial;
  logic            take;

  assign trial = {rem_q, q_q[SUMW-1]};
  assign take  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      it_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        it_q   <= IW'(SUMW);
      end else if (busy_q) begin
        it_q <= it_q - IW'(1);
        if (it_q == IW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SUMW-1];
      q_q   <= dividend_i[SUMW-1] ? SUMW'(-dividend_i) : SUMW'(dividend_i);
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= take ? CNTW'(trial - {1'b0, div_q}) : CNTW'(trial);
      q_q   <= {q_q[SUMW-2:0], take};
    end
  end

  assign quot_o     = neg_q ? -signed'(q_q) : signed'(q_q);
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule

[rtl/pool2d_max_avg_window_top.sv]
// ----------------------------------------------------------------------------
// pool2d_max_avg_window_top
// streaming 2-d max / average pooling over a line store of recent rows
// ----------------------------------------------------------------------------
// sequencing: an item that closes no window passes the row, finish and column
//   advance states; each closed row of windows adds a row and a column state,
//   each window one read per in-window sample (single read port of the line
//   store), in average mode the bit-serial divider too; a row end and each
//   retired window index add an advance state; throughput: one item at a time
// reset: registers to reset values, positions to zero, line store untouched
module pool2d_max_avg_window_top #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_KERNEL  = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // apb config port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [4:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // sample beats
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  // result beats
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] pooled_o,
  output logic [7:0]                    out_row_o,
  output logic [7:0]                    out_col_o,
  output logic                          run_end_o
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int KW   = $clog2(MAX_KERNEL);
  localparam int AW   = $clog2(MAX_KERNEL * MAX_WIDTH);
  localparam int CNTW = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
  localparam int SUMW = SAMPLE_BITS + CNTW;

  typedef pool2d_pkg::axis_t axis_t;

  // config registers
  logic       mode_q;
  logic [2:0] kernel_q, step_q;
  logic [1:0] pad_q;
  logic [8:0] height_q, width_q;

  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      kernel_q <= 3'd2;
      step_q   <= 3'd2;
      pad_q    <= 2'd0;
      height_q <= 9'd256;
      width_q  <= 9'd256;
    end else if (cfg_wr) begin
      unique case (pool2d_pkg::reg_e'(paddr[4:2]))
        pool2d_pkg::REG_MODE:   mode_q   <= pwdata[0];
        pool2d_pkg::REG_KERNEL: kernel_q <= pwdata[2:0];
        pool2d_pkg::REG_STEP:   step_q   <= pwdata[2:0];
        pool2d_pkg::REG_PAD:    pad_q    <= pwdata[1:0];
        pool2d_pkg::REG_HEIGHT: height_q <= pwdata[8:0];
        pool2d_pkg::REG_WIDTH:  width_q  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (pool2d_pkg::reg_e'(paddr[4:2]))
      pool2d_pkg::REG_MODE:   prdata = 32'(mode_q);
      pool2d_pkg::REG_KERNEL: prdata = 32'(kernel_q);
      pool2d_pkg::REG_STEP:   prdata = 32'(step_q);
      pool2d_pkg::REG_PAD:    prdata = 32'(pad_q);
      pool2d_pkg::REG_HEIGHT: prdata = 32'(height_q);
      pool2d_pkg::REG_WIDTH:  prdata = 32'(width_q);
      default:                prdata = '0;
    endcase
  end

  // effective geometry: zero means one, kernel and width saturate,
  // pad clamped to half the kernel
  axis_t k_eff, s_eff, p_eff, h_eff, w_eff, k_raw, w_raw;
  always_comb begin
    k_raw = axis_t'(kernel_q);
    k_eff = (kernel_q == 3'd0) ? axis_t'(1) :
            (k_raw > axis_t'(MAX_KERNEL)) ? axis_t'(MAX_KERNEL) : k_raw;
    s_eff = (step_q == 3'd0) ? axis_t'(1) : axis_t'(step_q);
    p_eff = (axis_t'(pad_q) > (k_eff >>> 1)) ? (k_eff >>> 1) : axis_t'(pad_q);
    h_eff = (height_q == 9'd0) ? axis_t'(1) : axis_t'(height_q);
    w_raw = axis_t'(width_q);
    w_eff = (width_q == 9'd0) ? axis_t'(1) :
            (w_raw > axis_t'(MAX_WIDTH)) ? axis_t'(MAX_WIDTH) : w_raw;
  end

  // sequencer state
  pool2d_pkg::state_e state_q, state_d;
  logic [8:0]    row_pos_q, row_pos_d;
  logic [CW-1:0] col_pos_q, col_pos_d;
  logic [KW-1:0] rslot_q, rslot_d;
  axis_t         ro_q, ro_d, co_q, co_d;     // first window not yet closed, per axis

  // per-item working registers
  axis_t         r_q, r_d, c_q, c_d, a_q, a_d, b_q, b_d, cbase_q, cbase_d;
  logic [KW-1:0] slot_q, slot_d;
  axis_t         y_q, y_d, x_q, x_d, xfirst_q, xfirst_d;
  logic [KW-1:0] yslot_q, yslot_d;

  // result staging: pending result waits until we know whether it is last
  logic                          pend_v_q, pend_v_d;
  logic signed [SAMPLE_BITS-1:0] pend_val_q, pend_val_d;
  logic [7:0]                    pend_row_q, pend_row_d, pend_col_q, pend_col_d;
  logic                          out_v_q, out_v_d, out_end_q, out_end_d;
  logic signed [SAMPLE_BITS-1:0] out_val_q, out_val_d;
  logic [7:0]                    out_row_q, out_row_d, out_col_q, out_col_d;

  // line store
  logic signed [SAMPLE_BITS-1:0] mem [MAX_KERNEL * MAX_WIDTH];
  logic signed [SAMPLE_BITS-1:0] rdata_q;
  logic                          rd_valid_q;
  logic                          we, re;
  logic [AW-1:0]                 waddr, raddr;

  // accumulators
  logic signed [SUMW-1:0]        sum_q;
  logic [CNTW-1:0]               cnt_q;
  logic signed [SAMPLE_BITS-1:0] max_q;
  logic                          acc_clr;

  // divider
  logic                   div_start;
  logic signed [SUMW-1:0] div_quot;
  pool2d_pkg::div_sts_t   div_sts;

  pool2d_pkg::win_t rw, cw;
  axis_t            row_o, col_o;
  logic             out_free;

  assign row_o    = (state_q == pool2d_pkg::S_RADV) ? ro_q : a_q;
  assign col_o    = (state_q == pool2d_pkg::S_CADV) ? co_q : b_q;
  assign rw       = pool2d_pkg::win_calc(row_o, s_eff, p_eff, k_eff, h_eff, r_q);
  assign cw       = pool2d_pkg::win_calc(col_o, s_eff, p_eff, k_eff, w_eff, c_q);
  assign out_free = !out_v_q || out_ready_i;
  assign in_ready_o = (state_q == pool2d_pkg::S_IDLE);

  always_comb begin
    logic                          out_of;
    logic [KW-1:0]                 slot_w;
    logic [CW-1:0]                 col_w;
    logic [KW-1:0]                 d;
    logic [KW:0]                   back;
    logic                          last_rd;
    logic signed [SAMPLE_BITS-1:0] res;

    state_d   = state_q;
    row_pos_d = row_pos_q;
    col_pos_d = col_pos_q;
    rslot_d   = rslot_q;
    ro_d      = ro_q;
    co_d      = co_q;
    r_d       = r_q;
    c_d       = c_q;
    a_d       = a_q;
    b_d       = b_q;
    cbase_d   = cbase_q;
    slot_d    = slot_q;
    y_d       = y_q;
    x_d       = x_q;
    xfirst_d  = xfirst_q;
    yslot_d   = yslot_q;
    pend_v_d  = pend_v_q;
    pend_val_d = pend_val_q;
    pend_row_d = pend_row_q;
    pend_col_d = pend_col_q;
    out_v_d   = out_v_q && !out_ready_i;
    out_end_d = out_end_q;
    out_val_d = out_val_q;
    out_row_d = out_row_q;
    out_col_d = out_col_q;
    we        = 1'b0;
    re        = 1'b0;
    acc_clr   = 1'b0;
    div_start = 1'b0;

    // position out of the plane restarts it
    out_of  = (axis_t'(row_pos_q) >= h_eff) || (axis_t'(col_pos_q) >= w_eff);
    slot_w  = out_of ? '0 : rslot_q;
    col_w   = out_of ? '0 : col_pos_q;
    waddr   = AW'(slot_w) * AW'(MAX_WIDTH) + AW'(col_w);
    raddr   = AW'(yslot_q) * AW'(MAX_WIDTH) + AW'(x_q[CW-1:0]);
    last_rd = (y_q == r_q) && (x_q == c_q);
    res     = mode_q ? div_quot[SAMPLE_BITS-1:0] : max_q;
    d       = KW'(r_q - rw.first);
    back    = {1'b0, slot_q} + (KW+1)'(MAX_KERNEL) - {1'b0, d};

    unique case (state_q)
      pool2d_pkg::S_IDLE: begin
        if (in_valid_i) begin
          we      = 1'b1;
          r_d     = out_of ? axis_t'(0) : axis_t'(row_pos_q);
          c_d     = axis_t'(col_w);
          slot_d  = slot_w;
          a_d     = out_of ? axis_t'(0) : ro_q;
          cbase_d = out_of ? axis_t'(0) : co_q;
          if (out_of) begin
            ro_d      = '0;
            co_d      = '0;
            rslot_d   = '0;
            row_pos_d = '0;
          end
          state_d = pool2d_pkg::S_ROW;
        end
      end
      pool2d_pkg::S_ROW: begin
        if (rw.hit) begin
          b_d     = cbase_q;
          state_d = pool2d_pkg::S_COL;
        end else begin
          state_d = pool2d_pkg::S_FIN;
        end
      end
      pool2d_pkg::S_COL: begin
        if (cw.hit) begin
          y_d      = rw.first;
          x_d      = cw.first;
          xfirst_d = cw.first;
          yslot_d  = (slot_q >= d) ? slot_q - d : KW'(back);
          acc_clr  = 1'b1;
          state_d  = pool2d_pkg::S_SCAN;
        end else begin
          a_d     = a_q + axis_t'(1);
          state_d = pool2d_pkg::S_ROW;
        end
      end
      pool2d_pkg::S_SCAN: begin
        re = 1'b1;
        if (x_q == c_q) begin
          x_d     = xfirst_q;
          y_d     = y_q + axis_t'(1);
          yslot_d = (yslot_q == KW'(MAX_KERNEL - 1)) ? '0 : yslot_q + KW'(1);
        end else begin
          x_d = x_q + axis_t'(1);
        end
        if (last_rd) state_d = pool2d_pkg::S_DRAIN;
      end
      pool2d_pkg::S_DRAIN: begin
        state_d = mode_q ? pool2d_pkg::S_DSTART : pool2d_pkg::S_EMIT;
      end
      pool2d_pkg::S_DSTART: begin
        div_start = 1'b1;
        state_d   = pool2d_pkg::S_DIV;
      end
      pool2d_pkg::S_DIV: begin
        if (div_sts.done) state_d = pool2d_pkg::S_EMIT;
      end
      pool2d_pkg::S_EMIT: begin
        if (!pend_v_q || out_free) begin
          if (pend_v_q) begin
            out_v_d   = 1'b1;
            out_end_d = 1'b0;
            out_val_d = pend_val_q;
            out_row_d = pend_row_q;
            out_col_d = pend_col_q;
          end
          pend_v_d   = 1'b1;
          pend_val_d = res;
          pend_row_d = a_q[7:0];
          pend_col_d = b_q[7:0];
          b_d        = b_q + axis_t'(1);
          state_d    = pool2d_pkg::S_COL;
        end
      end
      pool2d_pkg::S_FIN: begin
        if (!pend_v_q) begin
          state_d = pool2d_pkg::S_CADV;
        end else if (out_free) begin
          out_v_d   = 1'b1;
          out_end_d = 1'b1;
          out_val_d = pend_val_q;
          out_row_d = pend_row_q;
          out_col_d = pend_col_q;
          pend_v_d  = 1'b0;
          state_d   = pool2d_pkg::S_CADV;
        end
      end
      pool2d_pkg::S_CADV: begin
        if (cw.hit) begin
          co_d = co_q + axis_t'(1);
        end else if (c_q == w_eff - axis_t'(1)) begin
          co_d    = '0;
          state_d = pool2d_pkg::S_RADV;
        end else begin
          col_pos_d = CW'(c_q + axis_t'(1));
          state_d   = pool2d_pkg::S_IDLE;
        end
      end
      pool2d_pkg::S_RADV: begin
        if (rw.hit) begin
          ro_d = ro_q + axis_t'(1);
        end else begin
          col_pos_d = '0;
          if (r_q == h_eff - axis_t'(1)) begin
            ro_d      = '0;
            row_pos_d = '0;
            rslot_d   = '0;
          end else begin
            row_pos_d = 9'(r_q + axis_t'(1));
            rslot_d   = (slot_q == KW'(MAX_KERNEL - 1)) ? '0 : slot_q + KW'(1);
          end
          state_d = pool2d_pkg::S_IDLE;
        end
      end
      default: state_d = pool2d_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pool2d_pkg::S_IDLE;
      row_pos_q  <= '0;
      col_pos_q  <= '0;
      rslot_q    <= '0;
      ro_q       <= '0;
      co_q       <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      row_pos_q  <= row_pos_d;
      col_pos_q  <= col_pos_d;
      rslot_q    <= rslot_d;
      ro_q       <= ro_d;
      co_q       <= co_d;
      pend_v_q   <= pend_v_d;
      out_v_q    <= out_v_d;
      rd_valid_q <= re;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q        <= r_d;
    c_q        <= c_d;
    a_q        <= a_d;
    b_q        <= b_d;
    cbase_q    <= cbase_d;
    slot_q     <= slot_d;
    y_q        <= y_d;
    x_q        <= x_d;
    xfirst_q   <= xfirst_d;
    yslot_q    <= yslot_d;
    pend_val_q <= pend_val_d;
    pend_row_q <= pend_row_d;
    pend_col_q <= pend_col_d;
    out_end_q  <= out_end_d;
    out_val_q  <= out_val_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
  end

  // line store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= sample_i;
    if (re) rdata_q <= mem[raddr];
  end

  // sum, count and running maximum of the window
  always_ff @(posedge clk_i) begin
    if (acc_clr) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (rd_valid_q) begin
      sum_q <= sum_q + SUMW'(rdata_q);
      cnt_q <= cnt_q + CNTW'(1);
      if (cnt_q == '0 || rdata_q > max_q) max_q <= rdata_q;
    end
  end

  pool2d_div #(
    .SUMW (SUMW),
    .CNTW (CNTW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (cnt_q),
    .quot_o     (div_quot),
    .sts_o      (div_sts)
  );

  assign out_valid_o = out_v_q;
  assign pooled_o    = out_val_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign run_end_o   = out_end_q;

endmodule

[rtl/pool2d_chk.sv]
// ----------------------------------------------------------------------------
// pool2d_chk
// port-level checks on the pooling block, bound to the top level
// ----------------------------------------------------------------------------
`include "pool2d_max_avg_window_top_defines.svh"

module pool2d_chk #(
  parameter int SAMPLE_BITS = 16
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] pooled_o,
  input logic                   run_end_o,
  input logic                   pready
);

  // stalled result beat holds
  `POOL2D_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(pooled_o) && $stable(run_end_o))
  // an accepted sample keeps the block busy
  `POOL2D_ASSERT_NEXT(a_in_busy, in_valid_i && in_ready_o, !in_ready_o)
  // a result that is not the last of its run leaves the item unfinished
  `POOL2D_ASSERT_NEXT(a_mid_run, out_valid_o && out_ready_i && !run_end_o, !in_ready_o)
  // config port never waits
  `POOL2D_ASSERT_SAME(a_pready, 1'b1, pready)

endmodule

bind pool2d_max_avg_window_top pool2d_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_chk (.*);

[bench/pool2d_max_avg_window_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pool2d_max_avg_window_top_test
// streams sample planes through the pooling block under random valid/ready
// gaps, predicts every window max or average and checks each result beat
// ----------------------------------------------------------------------------
module pool2d_max_avg_window_top_test;

  localparam int LW = 256;
  localparam int LK = 7;

  typedef struct packed {
    logic signed [15:0] pooled;
    logic [7:0]         row;
    logic [7:0]         col;
    logic               last;
  } window_res_t;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic signed [15:0] sample_i, pooled_o;
  logic [7:0] out_row_o, out_col_o;
  logic run_end_o;

  pool2d_max_avg_window_top dut (.*);

  // shadow registers and line store of the predictor
  int cfg_mode, cfg_kernel, cfg_step, cfg_pad, cfg_height, cfg_width;
  int rows_seen, cols_seen;
  int lines [LK*LW];

  logic signed [15:0] sample_q [$];   // samples waiting to be driven
  window_res_t        window_q [$];   // predicted windows not yet seen
  int  errors = 0;
  bit  feeding_done = 0;
  bit  hold_input = 0;
  bit  in_acc = 0;                    // sample beat taken at the last rising edge

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("pool2d_max_avg_window_top_test NOT OK");
    $finish;
  end

  // windows on one axis whose clipped end sits at pos
  function automatic int axis_hits(int len, int k, int s, int p, int pos,
                                   output int idx [16], output int first [16]);
    int span, nout, st, en, n;
    n = 0;
    span = len + 2*p - k;
    if (span < 0) return 0;
    nout = span / s + 1;
    for (int o = 0; o < nout && n < 16; o++) begin
      st = o*s - p;
      en = st + k - 1;
      if (en > len - 1) en = len - 1;
      if (en == pos) begin
        idx[n] = o;
        first[n] = st < 0 ? 0 : st;
        n++;
      end
    end
    return n;
  endfunction

  // predicted windows closed by one accepted sample
  task automatic pool_sample(logic signed [15:0] smp);
    int k, s, p, h, w, r, c, nr, nc, n, cnt, v, acc, best;
    int ri [16], rf [16], ci [16], cf [16];
    window_res_t res;
    k = cfg_kernel == 0 ? 1 : cfg_kernel;
    s = cfg_step == 0 ? 1 : cfg_step;
    h = cfg_height == 0 ? 1 : cfg_height;
    w = cfg_width == 0 ? 1 : cfg_width;
    if (k > LK) k = LK;
    p = cfg_pad > k/2 ? k/2 : cfg_pad;
    if (w > LW) w = LW;
    if (rows_seen >= h || cols_seen >= w) begin
      rows_seen = 0;
      cols_seen = 0;
    end
    r = rows_seen;
    c = cols_seen;
    lines[(r % LK)*LW + c] = smp;
    nr = axis_hits(h, k, s, p, r, ri, rf);
    nc = axis_hits(w, k, s, p, c, ci, cf);
    n = 0;
    for (int a = 0; a < nr; a++)
      for (int b = 0; b < nc && n < 16; b++) begin
        acc = 0; cnt = 0; best = 0;
        for (int y = rf[a]; y <= r; y++)
          for (int x = cf[b]; x <= c; x++) begin
            v = lines[(y % LK)*LW + x];
            if (cnt == 0 || v > best) best = v;
            acc += v;
            cnt++;
          end
        if (cfg_mode != 0) best = acc / cnt;  // int division truncates toward zero
        res.pooled = best[15:0];
        res.row = ri[a][7:0];
        res.col = ci[b][7:0];
        res.last = 0;
        window_q.push_back(res);
        n++;
      end
    if (n > 0) window_q[$].last = 1;
    cols_seen++;
    if (cols_seen >= w) begin
      cols_seen = 0;
      rows_seen++;
      if (rows_seen >= h) rows_seen = 0;
    end
  endtask

  function automatic int gap_len();
    int d;
    d = $urandom_range(0, 99);
    if (d < 45) return 0;
    if (d < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver: one sample beat at a time, changes on the falling edge
  int in_gap = 0;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 0;
    end else if (in_valid_i && in_acc) begin
      // beat taken at the last rising edge
      if (sample_q.size() > 0 && !hold_input && gap_len() == 0) begin
        sample_i <= sample_q.pop_front();
      end else begin
        in_valid_i <= 0;
        in_gap = gap_len();
      end
    end else if (!in_valid_i) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (sample_q.size() > 0 && !hold_input) begin
        sample_i <= sample_q.pop_front();
        in_valid_i <= 1;
      end
    end
  end

  // prediction at the accepting edge
  always @(posedge clk_i) begin
    in_acc = rst_ni && in_valid_i && in_ready_o;
    if (in_acc) pool_sample(sample_i);
  end

  // consumer stalls
  int out_gap = 0;
  always @(negedge clk_i) begin
    if (out_gap > 0) begin
      out_ready_i <= 0;
      out_gap--;
    end else begin
      out_ready_i <= 1;
      out_gap = gap_len();
    end
  end

  // monitor: compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    window_res_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (window_q.size() == 0) begin
        $error("unexpected result beat pooled=%0d row=%0d col=%0d",
               pooled_o, out_row_o, out_col_o);
        errors++;
      end else begin
        exp_res = window_q.pop_front();
        if (pooled_o !== exp_res.pooled) begin
          $error("pooled exp %0d got %0d", exp_res.pooled, pooled_o); errors++;
        end
        if (out_row_o !== exp_res.row) begin
          $error("out_row exp %0d got %0d", exp_res.row, out_row_o); errors++;
        end
        if (out_col_o !== exp_res.col) begin
          $error("out_col exp %0d got %0d", exp_res.col, out_col_o); errors++;
        end
        if (run_end_o !== exp_res.last) begin
          $error("run_end exp %0d got %0d", exp_res.last, run_end_o); errors++;
        end
      end
    end
  end

  // apb write: setup then access, aligned to the falling edge
  task automatic reg_write(pool2d_pkg::reg_e idx, int val);
    @(negedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= 5'(4 * int'(idx)); pwdata <= val;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic set_cfg(int md, int k, int s, int p, int h, int w);
    reg_write(pool2d_pkg::REG_MODE, md);    cfg_mode = md;
    reg_write(pool2d_pkg::REG_KERNEL, k);   cfg_kernel = k;
    reg_write(pool2d_pkg::REG_STEP, s);     cfg_step = s;
    reg_write(pool2d_pkg::REG_PAD, p);      cfg_pad = p;
    reg_write(pool2d_pkg::REG_HEIGHT, h);   cfg_height = h;
    reg_write(pool2d_pkg::REG_WIDTH, w);    cfg_width = w;
  endtask

  // wait for the queues to empty, then let the block finish a silent sample
  task automatic drain();
    while (sample_q.size() > 0 || in_valid_i || window_q.size() > 0)
      @(negedge clk_i);
    repeat (400) @(negedge clk_i);
  endtask

  function automatic logic signed [15:0] rand_sample();
    int d;
    d = $urandom_range(0, 9);
    if (d == 0) return 16'sh8000;
    if (d == 1) return 16'sh7fff;
    if (d < 4) return 16'($urandom_range(0, 15)) - 16'sd8;
    return 16'($urandom);
  endfunction

  // queue whole planes so nothing ever reads an unwritten line entry
  task automatic feed_planes(int planes);
    int h, w;
    h = cfg_height == 0 ? 1 : cfg_height;
    w = cfg_width == 0 ? 1 : (cfg_width > LW ? LW : cfg_width);
    repeat (planes * h * w) sample_q.push_back(rand_sample());
  endtask

  initial begin
    int md, k, s, p, h, w, total;
    rst_ni = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid_i = 0; sample_i = 0; out_ready_i = 0;
    cfg_mode = 0; cfg_kernel = 2; cfg_step = 2; cfg_pad = 0;
    cfg_height = 256; cfg_width = 256;
    rows_seen = 0; cols_seen = 0;
    foreach (lines[i]) lines[i] = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: extremes of the sample, max then average, 3x3 pad 1
    set_cfg(0, 3, 2, 1, 3, 4);
    sample_q = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh5555, 16'shaaaa,
                 16'sh0001, 16'sh8001, 16'sh7ffe, 16'sh0100, 16'shff00, 16'sh1234};
    // pause the sender midway until all results are back
    while (sample_q.size() > 6) @(negedge clk_i);
    hold_input = 1;
    while (window_q.size() > 0 || in_valid_i) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    hold_input = 0;
    drain();
    set_cfg(1, 3, 2, 1, 3, 4);
    sample_q = '{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'shffff, 16'sh0003,
                 16'shfffd, 16'sh0002, 16'sh0001, 16'shffff, 16'sh7fff, 16'sh8000};
    drain();
    // zero kernel/step/size, pad 3 clamped to zero
    set_cfg(0, 0, 0, 3, 0, 0);
    feed_planes(3);
    drain();
    // plane smaller than the window: no results
    set_cfg(1, 7, 1, 0, 2, 3);
    feed_planes(1);
    drain();

    // random settings, one whole plane each
    total = 0;
    while (total < 120) begin
      md = $urandom_range(0, 1);
      k = $urandom_range(0, 7);
      s = $urandom_range(0, 7);
      p = $urandom_range(0, 3);
      h = $urandom_range(1, 6);
      w = $urandom_range(1, 10);
      if ($urandom_range(0, 9) == 0) h = 0;
      if ($urandom_range(0, 9) == 0) w = 0;
      set_cfg(md, k, s, p, h, w);
      feed_planes(1);
      total += sample_q.size();
      drain();
    end

    // width above the limit saturates to a full line, one row of max pooling
    set_cfg(0, 7, 7, 3, 1, 300);
    feed_planes(1);
    drain();
    set_cfg(0, 2, 2, 0, 256, 256);
    drain();
    if (errors == 0) begin
      $display("pool2d_max_avg_window_top_test OK");
    end else begin
      $display("pool2d_max_avg_window_top_test NOT OK");
    end
    $finish;
  end
endmodule
